// ===== src/vdp_pkg.sv =====
// shared constants and types for the rk4 oscillator core
// depends on nothing
package vdp_pkg;

    localparam int TABLE_DEPTH_DEF = 32768;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int NUM_REGS        = 8;

    localparam logic [2:0] REG_STEP_H    = 3'd0;
    localparam logic [2:0] REG_DAMP_GAIN = 3'd1;
    localparam logic [2:0] REG_DAMP_U1   = 3'd2;
    localparam logic [2:0] REG_DAMP_U2   = 3'd3;
    localparam logic [2:0] REG_STIFF_F   = 3'd4;
    localparam logic [2:0] REG_STIFF_D   = 3'd5;
    localparam logic [2:0] REG_STIFF_E   = 3'd6;
    localparam logic [2:0] REG_LENGTH    = 3'd7;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // coefficient set seen by the integrator
    typedef struct packed {
        logic signed [31:0] h;
        logic signed [31:0] a;
        logic signed [31:0] u1;
        logic signed [31:0] u2;
        logic signed [31:0] f;
        logic signed [31:0] d;
        logic signed [31:0] e;
    } coef_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== src/vdp_table.sv =====
// forcing table memory with one shared port and a registered synchronous read
// depends on vdp_pkg
module vdp_table #(
    parameter int TABLE_DEPTH = vdp_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       addr,
    input  logic signed [31:0]  wr_data,
    output logic signed [31:0]  rd_data
);
    import vdp_pkg::*;

    logic signed [31:0] mem [TABLE_DEPTH];
    logic signed [31:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_reg <= mem[addr];
    end

    assign rd_data = rd_reg;

endmodule

// ===== src/vdp_mul.sv =====
// fixed point multiplier: registered 32x32 product, then round, shift and saturate
// depends on vdp_pkg
module vdp_mul #(
    parameter int FRAC_BITS = vdp_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [31:0] prod
);
    import vdp_pkg::*;

    logic signed [63:0] p_reg;
    logic signed [64:0] rounded;
    logic signed [64:0] shifted;

    always_ff @(posedge aclk) begin
        p_reg <= op_a * op_b;
    end

    always_comb begin
        rounded = {p_reg[63], p_reg} + (65'sd1 <<< (FRAC_BITS - 1));
        shifted = rounded >>> FRAC_BITS;
        if (shifted > 65'sd2147483647) begin
            prod = 32'sh7fffffff;
        end else if (shifted < -65'sd2147483648) begin
            prod = 32'sh80000000;
        end else begin
            prod = shifted[31:0];
        end
    end

endmodule

// ===== src/vdp_core.sv =====
// rk4 sequencer: one shared multiplier, table reads, state update and rr tracking
// depends on vdp_pkg, vdp_mul, vdp_table
module vdp_core #(
    parameter int TABLE_DEPTH = vdp_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = vdp_pkg::FRAC_BITS_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  vdp_pkg::coef_t     coef,
    input  logic [15:0]        length,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_func,
    input  logic [14:0]        in_addr,
    input  logic signed [31:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_count,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic               out_rr_valid,
    output logic [31:0]        out_rr_steps
);
    import vdp_pkg::*;

    localparam logic signed [31:0] X_RST = -32'(((64'sd1 <<< FRAC_BITS) + 5) / 10);
    localparam logic signed [31:0] Y_RST = 32'(((64'sd1 <<< FRAC_BITS) + 20) / 40);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_STAGE, S_MUL, S_MWAIT, S_ACC, S_DIV, S_FIN
    } state_t;

    state_t state_reg;
    // stage 0..3 of rk4, operation 0..7 within stage
    logic [1:0]  stage_reg;
    logic [3:0]  op_reg;
    logic signed [31:0] x_reg, y_reg, xa_reg, ya_reg;
    logic signed [31:0] gl_reg, gn_reg, gm_reg;
    logic signed [31:0] t1_reg, t2_reg, p_reg, q_reg, k_reg;
    logic signed [35:0] dx_reg, dy_reg;
    logic [31:0] count_reg, last_reg;
    logic        seen_reg;
    logic [AW-1:0] pos_reg;
    logic [AW:0]   len_eff;
    logic          at_end;
    logic [2:0]    div_cnt_reg;
    logic signed [35:0] qx_reg, qy_reg;
    logic [35:0]   magx, magy;
    logic [34:0]   mx_reg, my_reg;
    logic [70:0]   sx_reg, sy_reg;

    logic               tbl_we;
    logic [AW-1:0]      tbl_addr;
    logic signed [31:0] tbl_rd;
    logic signed [31:0] mul_a, mul_b, mul_p;
    logic signed [31:0] g_sel, acc_val, xsub1, xsub2, xadd1, xadd2;
    logic signed [31:0] xn, yn;

    vdp_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .aclk(aclk), .wr_en(tbl_we), .addr(tbl_addr), .wr_data(in_value), .rd_data(tbl_rd)
    );

    vdp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk(aclk), .op_a(mul_a), .op_b(mul_b), .prod(mul_p)
    );

    always_comb begin
        if (length < 16'd2) begin
            len_eff = (AW+1)'(2);
        end else if (32'(length) > TABLE_DEPTH) begin
            len_eff = (AW+1)'(TABLE_DEPTH);
        end else begin
            len_eff = (AW+1)'(length);
        end
    end

    assign at_end   = ({1'b0, pos_reg} == len_eff - 1'b1);
    assign in_ready = (state_reg == S_IDLE) && !out_valid;
    assign tbl_we   = in_valid && in_ready && (in_func == FUNC_LOAD)
                      && (32'(in_addr) < TABLE_DEPTH);
    always_comb begin
        if (state_reg == S_RD1) begin
            tbl_addr = pos_reg + 1'b1;
        end else if (state_reg == S_IDLE) begin
            tbl_addr = in_func == FUNC_LOAD ? AW'(in_addr) : pos_reg;
        end else begin
            tbl_addr = pos_reg;
        end
    end

    assign xsub1 = sat32(36'(xa_reg) - 36'(coef.u1));
    assign xsub2 = sat32(36'(xa_reg) - 36'(coef.u2));
    assign xadd1 = sat32(36'(xa_reg) + 36'(coef.d));
    assign xadd2 = sat32(36'(xa_reg) + 36'(coef.e));

    always_comb begin
        unique case (stage_reg)
            2'd0:    g_sel = gl_reg;
            2'd3:    g_sel = gn_reg;
            default: g_sel = gm_reg;
        endcase
    end
    assign acc_val = sat32(-36'(p_reg) - 36'(q_reg) + 36'(g_sel));

    // operand schedule of one stage
    always_comb begin
        mul_a = coef.h;
        mul_b = ya_reg;
        case (op_reg)
            4'd0: begin mul_a = coef.h; mul_b = ya_reg; end
            4'd1: begin mul_a = coef.a; mul_b = ya_reg; end
            4'd2: begin mul_a = t1_reg; mul_b = xsub1;  end
            4'd3: begin mul_a = t1_reg; mul_b = xsub2;  end
            4'd4: begin mul_a = coef.f; mul_b = xa_reg; end
            4'd5: begin mul_a = t1_reg; mul_b = xadd1;  end
            4'd6: begin mul_a = t1_reg; mul_b = xadd2;  end
            4'd7: begin mul_a = coef.h; mul_b = acc_val; end
            default: begin mul_a = coef.h; mul_b = ya_reg; end
        endcase
    end

    assign xn = sat32(36'(x_reg) + qx_reg);
    assign yn = sat32(36'(y_reg) + qy_reg);

    // magnitudes of the weighted slope sums for the divide by six
    assign magx = dx_reg[35] ? 36'(-dx_reg) : 36'(dx_reg);
    assign magy = dy_reg[35] ? 36'(-dy_reg) : 36'(dy_reg);

    logic signed [32:0] gsum;
    assign gsum = 33'(gl_reg) + 33'(tbl_rd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            out_valid  <= 1'b0;
            x_reg      <= X_RST;
            y_reg      <= Y_RST;
            count_reg  <= '0;
            last_reg   <= '0;
            seen_reg   <= 1'b0;
            pos_reg    <= '0;
            stage_reg  <= '0;
            op_reg     <= '0;
            div_cnt_reg <= '0;
        end else begin
            if (out_valid && out_ready) begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready && in_func == FUNC_STEP) begin
                        if ({1'b0, pos_reg} >= len_eff) begin
                            pos_reg <= '0;
                            state_reg <= S_RD2;
                        end else begin
                            state_reg <= S_RD0;
                        end
                    end
                end
                S_RD2: state_reg <= S_RD0; // position restarted, reissue read
                S_RD0: state_reg <= S_RD1;
                S_RD1: begin
                    gl_reg <= tbl_rd;
                    state_reg <= S_STAGE;
                    // at this point tbl_rd holds T[p], next cycle T[p+1]
                end
                S_STAGE: begin
                    if (at_end) begin
                        gl_reg <= '0;
                        gn_reg <= '0;
                        gm_reg <= '0;
                    end else begin
                        gn_reg <= tbl_rd;
                        gm_reg <= 32'(gsum >>> 1);
                    end
                    xa_reg <= x_reg;
                    ya_reg <= y_reg;
                    stage_reg <= '0;
                    op_reg <= '0;
                    dx_reg <= '0;
                    dy_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: state_reg <= S_MWAIT;
                S_MWAIT: begin
                    case (op_reg) inside
                        4'd0: k_reg <= mul_p;
                        4'd1, 4'd2, 4'd4, 4'd5: t1_reg <= mul_p;
                        4'd3: p_reg <= mul_p;
                        4'd6: q_reg <= mul_p;
                        default: t2_reg <= mul_p;
                    endcase
                    if (op_reg == 4'd7) begin
                        state_reg <= S_ACC;
                    end else begin
                        op_reg <= op_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_ACC: begin
                    // k_reg is this stage's dx slope, t2_reg its dy slope
                    if (stage_reg == 2'd0 || stage_reg == 2'd3) begin
                        dx_reg <= dx_reg + 36'(k_reg);
                        dy_reg <= dy_reg + 36'(t2_reg);
                    end else begin
                        dx_reg <= dx_reg + (36'(k_reg) <<< 1);
                        dy_reg <= dy_reg + (36'(t2_reg) <<< 1);
                    end
                    if (stage_reg == 2'd2) begin
                        xa_reg <= sat32(36'(x_reg) + 36'(k_reg));
                        ya_reg <= sat32(36'(y_reg) + 36'(t2_reg));
                    end else begin
                        xa_reg <= sat32(36'(x_reg) + 36'(k_reg >>> 1));
                        ya_reg <= sat32(36'(y_reg) + 36'(t2_reg >>> 1));
                    end
                    op_reg <= '0;
                    if (stage_reg == 2'd3) begin
                        state_reg <= S_DIV;
                        div_cnt_reg <= '0;
                    end else begin
                        stage_reg <= stage_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_DIV: begin
                    // truncating divide by six on the magnitude: halve, then
                    // m/3 = (m * 0x555555555 + m) >> 36, built from shifted sums
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    case (div_cnt_reg)
                        3'd0: begin
                            mx_reg <= magx[35:1];
                            my_reg <= magy[35:1];
                        end
                        3'd1: begin
                            sx_reg <= 71'(mx_reg) + (71'(mx_reg) << 2);
                            sy_reg <= 71'(my_reg) + (71'(my_reg) << 2);
                        end
                        3'd2: begin
                            sx_reg <= sx_reg + (sx_reg << 4);
                            sy_reg <= sy_reg + (sy_reg << 4);
                        end
                        3'd3: begin
                            sx_reg <= sx_reg + (sx_reg << 8);
                            sy_reg <= sy_reg + (sy_reg << 8);
                        end
                        3'd4: begin
                            sx_reg <= sx_reg + (sx_reg << 16);
                            sy_reg <= sy_reg + (sy_reg << 16);
                        end
                        3'd5: begin
                            sx_reg <= sx_reg + ((71'(mx_reg) + (71'(mx_reg) << 2)) << 32)
                                      + 71'(mx_reg);
                            sy_reg <= sy_reg + ((71'(my_reg) + (71'(my_reg) << 2)) << 32)
                                      + 71'(my_reg);
                        end
                        default: begin
                            qx_reg <= dx_reg[35] ? -$signed({1'b0, sx_reg[70:36]})
                                                 : $signed({1'b0, sx_reg[70:36]});
                            qy_reg <= dy_reg[35] ? -$signed({1'b0, sy_reg[70:36]})
                                                 : $signed({1'b0, sy_reg[70:36]});
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_FIN: begin
                    if (!out_valid) begin
                        x_reg <= xn;
                        y_reg <= yn;
                        count_reg <= count_reg + 1'b1;
                        out_count <= count_reg + 1'b1;
                        out_x <= xn;
                        out_y <= yn;
                        out_rr_valid <= 1'b0;
                        out_rr_steps <= '0;
                        if (y_reg > 0 && yn <= 0) begin
                            if (seen_reg) begin
                                out_rr_valid <= 1'b1;
                                out_rr_steps <= count_reg + 1'b1 - last_reg;
                            end
                            last_reg <= count_reg + 1'b1;
                            seen_reg <= 1'b1;
                        end
                        if ({1'b0, pos_reg} + 1'b1 >= len_eff) begin
                            pos_reg <= '0;
                        end else begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                        out_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted while stepping");
    a_rr_needs_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_rr_valid) |-> seen_reg)
        else $error("rr reported before first crossing");
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STAGE) |-> ({1'b0, pos_reg} < len_eff))
        else $error("table position out of range");
`endif

endmodule

// ===== src/sa_node_oscillator_rk4_core.sv =====
// forced modified van der Pol oscillator, one rk4 step per step transfer
// sequence of a step: table reads (with an extra read when the position restarts), then
//   4 rk4 stages of 8 products each plus an accumulate, a divide by six, and the state update
// a new step is accepted only once the previous result has been transferred
// a table load gives no result; no transfer while a result waits
// reset: synchronous active-low aresetn restores state, counters, position and config registers; table is unset
module sa_node_oscillator_rk4_core #(
    parameter int TABLE_DEPTH = vdp_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = vdp_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [14:0]        s_table_addr,
    input  logic signed [31:0] s_table_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_step_count,
    output logic signed [31:0] m_x_out,
    output logic signed [31:0] m_y_out,
    output logic               m_rr_valid,
    output logic [31:0]        m_rr_steps
);
    import vdp_pkg::*;

    // step size 0.002 at the chosen fraction width
    localparam logic signed [31:0] H_RST = 32'(((64'sd1 <<< FRAC_BITS) + 250) / 500);

    coef_t       coef_reg;
    logic [15:0] len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '{h: H_RST, default: '0};
            len_reg  <= 16'd32768;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STEP_H:    coef_reg.h  <= cfg_data;
                REG_DAMP_GAIN: coef_reg.a  <= cfg_data;
                REG_DAMP_U1:   coef_reg.u1 <= cfg_data;
                REG_DAMP_U2:   coef_reg.u2 <= cfg_data;
                REG_STIFF_F:   coef_reg.f  <= cfg_data;
                REG_STIFF_D:   coef_reg.d  <= cfg_data;
                REG_STIFF_E:   coef_reg.e  <= cfg_data;
                REG_LENGTH:    len_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    vdp_core #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .coef(coef_reg), .length(len_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_func(s_func),
        .in_addr(s_table_addr), .in_value(s_table_value),
        .out_valid(m_valid), .out_ready(m_ready), .out_count(m_step_count),
        .out_x(m_x_out), .out_y(m_y_out), .out_rr_valid(m_rr_valid),
        .out_rr_steps(m_rr_steps)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for sa_node_oscillator_rk4_core: rk4 step predictor and scoreboard
// depends on vdp_pkg and the core rtl
`timescale 1ns / 100ps

typedef struct {
    logic [31:0]        count;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               rr_valid;
    logic [31:0]        rr_steps;
} osc_result_t;

class osc_scoreboard;
    int                 errors;
    osc_result_t        pending_steps[$];
    logic signed [31:0] coef[7];
    logic [15:0]        length_reg;
    logic signed [31:0] forcing[32768];
    bit                 loaded[32768];
    logic signed [31:0] x_now, y_now;
    logic [31:0]        steps_done, last_cross;
    int                 position;
    bit                 cross_seen;

    function new();
        errors = 0;
        coef[0] = 32'sd33554;
        for (int i = 1; i < 7; i++) coef[i] = '0;
        length_reg = 16'd32768;
        x_now = -32'sd1677722;
        y_now = 32'sd419430;
        steps_done = 0;
        last_cross = 0;
        position = 0;
        cross_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
        if (idx == vdp_pkg::REG_LENGTH) length_reg = data[15:0];
        else coef[idx] = data;
    endfunction

    function int eff_length();
        if (length_reg < 2) return 2;
        if (length_reg > 32768) return 32768;
        return length_reg;
    endfunction

    // current table position after the wrap rule
    function int cur_position();
        return (position >= eff_length()) ? 0 : position;
    endfunction

    function logic signed [31:0] clip(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< 23);
        return clip(p >>> 24);
    endfunction

    function logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
        return clip(longint'(a) + longint'(b));
    endfunction

    function logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
        return clip(longint'(a) - longint'(b));
    endfunction

    function logic signed [31:0] deriv_y(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] g);
        logic signed [31:0] damp, stiff;
        damp  = qmul(qmul(qmul(coef[1], y), qsub(x, coef[2])), qsub(x, coef[3]));
        stiff = qmul(qmul(qmul(coef[4], x), qadd(x, coef[5])), qadd(x, coef[6]));
        return clip(-longint'(damp) - longint'(stiff) + longint'(g));
    endfunction

    function void take_step();
        int                 len, pos;
        logic signed [31:0] gl, gn, gm, h, k1, k2, k3, k4, m1, m2, m3, m4, xa, ya, x1, y1;
        longint             dx, dy;
        osc_result_t        r;
        len = eff_length();
        pos = cur_position();
        gl = 0; gn = 0; gm = 0;
        if (pos != len - 1) begin
            gl = forcing[pos];
            gn = forcing[pos + 1];
            gm = 32'((longint'(gl) + longint'(gn)) >>> 1);
        end
        h  = coef[0];
        k1 = qmul(h, y_now);
        m1 = qmul(h, deriv_y(x_now, y_now, gl));
        xa = qadd(x_now, k1 >>> 1);
        ya = qadd(y_now, m1 >>> 1);
        k2 = qmul(h, ya);
        m2 = qmul(h, deriv_y(xa, ya, gm));
        xa = qadd(x_now, k2 >>> 1);
        ya = qadd(y_now, m2 >>> 1);
        k3 = qmul(h, ya);
        m3 = qmul(h, deriv_y(xa, ya, gm));
        xa = qadd(x_now, k3);
        ya = qadd(y_now, m3);
        k4 = qmul(h, ya);
        m4 = qmul(h, deriv_y(xa, ya, gn));
        dx = (longint'(k1) + 2 * longint'(k2) + 2 * longint'(k3) + longint'(k4)) / 6;
        dy = (longint'(m1) + 2 * longint'(m2) + 2 * longint'(m3) + longint'(m4)) / 6;
        x1 = clip(longint'(x_now) + dx);
        y1 = clip(longint'(y_now) + dy);
        r.count = steps_done + 1;
        r.rr_valid = 0;
        r.rr_steps = 0;
        // falling zero crossing of y closes an interval
        if (y_now > 0 && y1 <= 0) begin
            if (cross_seen) begin
                r.rr_valid = 1;
                r.rr_steps = r.count - last_cross;
            end
            last_cross = r.count;
            cross_seen = 1;
        end
        r.x = x1;
        r.y = y1;
        x_now = x1;
        y_now = y1;
        steps_done = r.count;
        pos++;
        position = (pos >= len) ? 0 : pos;
        pending_steps.push_back(r);
    endfunction

    function void note_input(logic func, logic [14:0] addr, logic signed [31:0] value);
        if (func == vdp_pkg::FUNC_LOAD) begin
            forcing[addr] = value;
            loaded[addr] = 1;
        end else begin
            take_step();
        end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_result(osc_result_t got);
        osc_result_t want;
        if (pending_steps.size() == 0) begin
            report("unexpected result step", got.count, '0);
            return;
        end
        want = pending_steps.pop_front();
        if (got.count !== want.count) report("step_count", got.count, want.count);
        if (got.x !== want.x) report("x_out", got.x, want.x);
        if (got.y !== want.y) report("y_out", got.y, want.y);
        if (got.rr_valid !== want.rr_valid)
            report("rr_valid", 32'(got.rr_valid), 32'(want.rr_valid));
        if (got.rr_steps !== want.rr_steps) report("rr_steps", got.rr_steps, want.rr_steps);
    endtask
endclass

module tb;
    import vdp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_func = 0;
    logic [14:0]        s_table_addr = '0;
    logic signed [31:0] s_table_value = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [31:0]        m_step_count;
    logic signed [31:0] m_x_out;
    logic signed [31:0] m_y_out;
    logic               m_rr_valid;
    logic [31:0]        m_rr_steps;

    osc_scoreboard sb = new();
    bit            no_idle = 0;
    int            out_stall = 0;
    int            quiet_cycles = 0;

    sa_node_oscillator_rk4_core dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // result side: check each transfer, then stall a random number of cycles unless no_idle is set
    always @(posedge aclk) begin
        osc_result_t r;
        if (m_valid && m_ready) begin
            r.count = m_step_count;
            r.x = m_x_out;
            r.y = m_y_out;
            r.rr_valid = m_rr_valid;
            r.rr_steps = m_rr_steps;
            sb.check_result(r);
            out_stall = no_idle ? 0 : $urandom_range(0, 9);
        end else if (out_stall > 0) begin
            out_stall--;
        end
        m_ready <= aresetn && out_stall == 0 && !(m_valid && m_ready && !no_idle);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.set_reg(idx, data);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task send_item(logic func, logic [14:0] addr, logic signed [31:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1;
        s_func        <= func;
        s_table_addr  <= addr;
        s_table_value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(func, addr, value);
    endtask

    // a step only once both table entries it reads have been loaded
    task send_step(bit wide);
        int pos;
        pos = sb.cur_position();
        if (pos != sb.eff_length() - 1) begin
            for (int i = pos; i <= pos + 1; i++)
                if (!sb.loaded[i]) send_item(FUNC_LOAD, 15'(i), forcing_value(wide));
        end
        send_item(FUNC_STEP, 15'($urandom), $urandom);
    endtask

    function logic signed [31:0] forcing_value(bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endfunction

    task settle();
        s_valid <= 0;
        while (sb.pending_steps.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task set_coefs(logic [31:0] h, a, u1, u2, f, d, e, logic [31:0] len);
        settle();
        write_reg(REG_STEP_H, h);
        write_reg(REG_DAMP_GAIN, a);
        write_reg(REG_DAMP_U1, u1);
        write_reg(REG_DAMP_U2, u2);
        write_reg(REG_STIFF_F, f);
        write_reg(REG_STIFF_D, d);
        write_reg(REG_STIFF_E, e);
        write_reg(REG_LENGTH, len);
    endtask

    task run_phase(int n, bit wide);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) no_idle = !no_idle;
            if ($urandom_range(0, 3) == 0)
                send_item(FUNC_LOAD, 15'($urandom), forcing_value(wide));
            else
                send_step(wide);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: table extremes, top address, steps with reset settings
        send_item(FUNC_LOAD, 15'd0, 32'sh7fffffff);
        send_item(FUNC_LOAD, 15'd1, 32'sh80000000);
        send_item(FUNC_LOAD, 15'h7fff, 32'sh55555555);
        send_item(FUNC_LOAD, 15'h2aaa, 32'shaaaaaaaa);
        send_item(FUNC_LOAD, 15'd2, -32'sd1);
        for (int i = 0; i < 4; i++) send_step(0);
        // length below two, then a wrap at the last entry
        set_coefs(32'd33554, 0, 0, 0, 0, 0, 0, 16'd1);
        for (int i = 0; i < 4; i++) send_step(0);

        // limit cycle oscillator with clear rr intervals
        set_coefs(32'd1677722, 32'd8388608, -32'sd8388608, 32'd8388608,
                  32'd67108864, 32'd16777216, 32'd16777216, 16'd16);
        run_phase(250, 0);
        set_coefs(32'd838861, 32'd16777216, -32'sd16777216, 32'd16777216,
                  32'd33554432, 32'd25165824, 32'd25165824, 16'd0);
        run_phase(250, 0);
        // length beyond the table depth
        set_coefs(32'd1677722, 32'd8388608, -32'sd8388608, 32'd8388608,
                  32'd67108864, 32'd16777216, 32'd16777216, 16'hffff);
        run_phase(150, 0);
        set_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'd2);
        run_phase(150, 1);
        set_coefs(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000, 16'd32768);
        run_phase(150, 1);
        set_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(2, 40));
        run_phase(200, 1);
        // bring the state back into range, then moderate random settings
        set_coefs(32'd1677722, 32'd8388608, -32'sd8388608, 32'd8388608,
                  32'd67108864, 32'd16777216, 32'd16777216, 16'd32);
        run_phase(100, 0);
        set_coefs($urandom_range(0, 3355443), $urandom_range(0, 33554432),
                  -$urandom_range(0, 16777216), $urandom_range(0, 16777216),
                  $urandom_range(16777216, 100663296), $urandom_range(8388608, 33554432),
                  $urandom_range(8388608, 33554432), $urandom_range(2, 64));
        run_phase(200, 0);

        settle();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/vdp_pkg.sv
src/vdp_table.sv
src/vdp_mul.sv
src/vdp_core.sv
src/sa_node_oscillator_rk4_core.sv
tb/tb.sv
